// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define FWRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen on a clock edge outside reset
`define FWRM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/fwrm_pkg.sv =====
// shared constants and types for the window running median
package fwrm_pkg;

  localparam int unsigned DefaultDepth      = 64;
  localparam int unsigned DefaultValueWidth = 32;

  // func codes
  localparam logic FuncPush = 1'b0;
  localparam logic FuncPop  = 1'b1;

  // error codes
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrFull  = 2'd1;
  localparam logic [1:0] ErrEmpty = 2'd2;

  // operation broadcast to every cell of the sorted chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_op_t;

endpackage

// ===== rtl/fwrm_ram.sv =====
// generic single-write, single-read ram with registered read data
module fwrm_ram #(
  parameter int unsigned WIDTH = fwrm_pkg::DefaultValueWidth,
  parameter int unsigned DEPTH = fwrm_pkg::DefaultDepth,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/fwrm_cell.sv =====
// one slot of the sorted chain: compare, insert or shift per operation
module fwrm_cell #(
  parameter int unsigned VALUE_WIDTH = fwrm_pkg::DefaultValueWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fwrm_pkg::cell_op_t            op_i,
  input  logic signed [VALUE_WIDTH-1:0] operand_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic                          left_valid_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  input  logic                          right_valid_i,
  input  logic                          kill_i,
  output logic                          kill_o,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          valid_o
);

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          valid_q, valid_d;
  logic                          left_gt;
  logic                          self_gt;
  logic                          match;

  // insertion compare against own slot and the lower neighbor
  assign left_gt = left_valid_i && (left_value_i > operand_i);
  assign self_gt = !valid_q || (value_q > operand_i);

  // removal: first matching copy and every slot above it shift down
  assign match  = valid_q && (value_q == operand_i);
  assign kill_o = kill_i || match;

  // next slot contents
  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (op_i.push) begin
      if (left_gt) begin
        value_d = left_value_i;
        valid_d = 1'b1;
      end else if (left_valid_i && self_gt) begin
        value_d = operand_i;
        valid_d = 1'b1;
      end
    end else if (op_i.pop && kill_o) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end
  end

  // slot valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/fifo_window_running_median.sv =====
// top level: arrival ram, sorted cell chain and command sequencer
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------
//  command  | in        | start_i / busy_o    | func_i, value_i
//  result   | out       | done_o (strobe)     | median_o, count_o, empty_res_o, error_o
//
// a transaction is taken at an edge with start_i high and busy_o low.
// each transaction steps through accept (arrival ram write or read),
// apply (all cells of the sorted chain update together), report (median
// picked by rank from the chain and registered). done_o pulses in the
// cycle after report, together with the next possible accept.
// reset clears the pointers, count and cell valid flags; no clearing pass.
// the receiver cannot stall; results are never held back.
module fifo_window_running_median #(
  parameter int unsigned DEPTH       = fwrm_pkg::DefaultDepth,
  parameter int unsigned VALUE_WIDTH = fwrm_pkg::DefaultValueWidth,
  localparam int unsigned CountW     = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          func_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] median_o,
  output logic [CountW-1:0]             count_o,
  output logic                          empty_res_o,
  output logic [1:0]                    error_o
);

  `include "assert_macros.svh"

  localparam int unsigned PtrW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StApply  = 3'b010,
    StReport = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [PtrW-1:0]               head_q, tail_q;
  logic [CountW-1:0]             count_q;
  fwrm_pkg::cell_op_t            op_q;
  logic signed [VALUE_WIDTH-1:0] push_value_q;
  logic [1:0]                    err_q;
  logic                          done_q;
  logic signed [VALUE_WIDTH-1:0] median_q;
  logic [CountW-1:0]             count_out_q;
  logic [1:0]                    error_out_q;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          do_push;
  logic                          do_pop;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] operand;
  fwrm_pkg::cell_op_t            cell_op;
  logic [CountW-1:0]             rank;
  logic signed [VALUE_WIDTH-1:0] picked;

  logic signed [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]              cell_valid;
  logic [DEPTH:0]                kill;

  // command decode
  assign busy_o  = (state_q != StIdle);
  assign accept  = start_i && !busy_o;
  assign full    = (count_q == CountW'(DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = accept && (func_i == fwrm_pkg::FuncPush) && !full;
  assign do_pop  = accept && (func_i == fwrm_pkg::FuncPop) && !empty;

  // arrival order store
  fwrm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_arrival (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (tail_q),
    .wdata_i (value_i),
    .re_i    (do_pop),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept) state_d = StApply;
      StApply:  state_d = StReport;
      StReport: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      op_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StReport);
      if (accept) begin
        op_q.push <= do_push;
        op_q.pop  <= do_pop;
      end
      if (do_push) begin
        tail_q <= (tail_q == PtrW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
      end
      if (do_pop) begin
        head_q <= (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      end
      if (state_q == StApply) begin
        if (op_q.push) begin
          count_q <= count_q + 1'b1;
        end else if (op_q.pop) begin
          count_q <= count_q - 1'b1;
        end
      end
    end
  end

  // transaction payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      push_value_q <= value_i;
      if (func_i == fwrm_pkg::FuncPush) begin
        err_q <= full ? fwrm_pkg::ErrFull : fwrm_pkg::ErrNone;
      end else begin
        err_q <= empty ? fwrm_pkg::ErrEmpty : fwrm_pkg::ErrNone;
      end
    end
  end

  // chain operand: new value on push, oldest value from ram on pop
  assign operand      = op_q.pop ? $signed(ram_rdata) : push_value_q;
  assign cell_op.push = op_q.push && (state_q == StApply);
  assign cell_op.pop  = op_q.pop && (state_q == StApply);
  assign kill[0]      = 1'b0;

  // sorted cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic                          left_valid;
    logic signed [VALUE_WIDTH-1:0] right_value;
    logic                          right_valid;

    if (i == 0) begin : g_first
      assign left_value = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    fwrm_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (cell_op),
      .operand_i     (operand),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .kill_i        (kill[i]),
      .kill_o        (kill[i+1]),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i])
    );
  end

  // median pick: and-or select of the slot at rank count/2
  assign rank = count_q >> 1;
  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rank == CountW'(i)) begin
        picked = picked | cell_value[i];
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (state_q == StReport) begin
      median_q    <= empty ? '0 : picked;
      count_out_q <= count_q;
      error_out_q <= err_q;
    end
  end

  assign done_o      = done_q;
  assign median_o    = median_q;
  assign count_o     = count_out_q;
  assign empty_res_o = (count_out_q == '0);
  assign error_o     = error_out_q;

  // checks
  `FWRM_ASSERT(a_valid_matches_count, $countones(cell_valid) == 32'(count_q),
    "sorted chain occupancy differs from count")
  `FWRM_NEVER(a_count_range, count_q > CountW'(DEPTH), "count above depth")
  `FWRM_ASSERT(a_done_after_report, done_o |-> $past(state_q == StReport),
    "result strobe without report step")
  `FWRM_ASSERT(a_full_error_count, (done_o && (error_o == fwrm_pkg::ErrFull)) |->
    (count_o == CountW'(DEPTH)), "full error reported below depth")

endmodule
